@@ src/seven_segment_scan_blink_macros.svh @@
// Assertion macros used by the display controller checker.
`ifndef SEVEN_SEGMENT_SCAN_BLINK_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_BLINK_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ssb_pkg.sv @@
// Shared types, constants and helper functions of the display controller.
`timescale 1ns / 1ps

package ssb_pkg;

    localparam int MAX_DIGITS = 8;
    localparam int DIGIT_W    = 3;
    localparam int NUM_W      = 4;
    localparam int PERIOD_W   = 16;
    localparam int MASK_W     = 8;
    localparam int SEG_W      = 8;
    localparam int VALUES_W   = 32;
    localparam int DOT_BIT    = 7;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    localparam logic [DIGIT_W-1:0] ALARM_DIGIT = 3'd3;

    // Item modes
    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_TOGGLE  = 2'd1;
    localparam logic [1:0] MODE_REFRESH = 2'd2;

    // Register word indexes
    localparam logic [2:0] REG_DIGITS       = 3'd0;
    localparam logic [2:0] REG_DIGIT_PERIOD = 3'd1;
    localparam logic [2:0] REG_DIGIT_MASK   = 3'd2;
    localparam logic [2:0] REG_DOT_PERIOD   = 3'd3;
    localparam logic [2:0] REG_DOT_MASK     = 3'd4;
    localparam logic [2:0] REG_ALARM        = 3'd5;

    typedef struct packed {
        logic [NUM_W-1:0]    digits_in_use;
        logic [PERIOD_W-1:0] digit_blink_period;
        logic [MASK_W-1:0]   digit_blink_mask;
        logic [PERIOD_W-1:0] dot_blink_period;
        logic [MASK_W-1:0]   dot_blink_mask;
        logic                alarm_dot;
    } cfg_t;

    // One-cycle side effects of register writes, seen in the same cycle as the new value lands
    typedef struct packed {
        logic restart;
        logic digit_cnt_clr;
        logic dot_cnt_clr;
    } cfg_evt_t;

    typedef struct packed {
        logic [1:0]          mode;
        logic [VALUES_W-1:0] digit_values;
        logic [NUM_W-1:0]    value_count;
        logic [DIGIT_W-1:0]  position;
    } item_t;

    typedef struct packed {
        logic [SEG_W-1:0]   segments;
        logic [DIGIT_W-1:0] digit_select;
    } result_t;

    // BCD digit to segment image, A at bit 0; non-decimal codes show blank
    function automatic logic [SEG_W-1:0] seg_image(input logic [3:0] nib);
        logic [SEG_W-1:0] img;
        case (nib)
            4'd0:    img = 8'h3F;
            4'd1:    img = 8'h06;
            4'd2:    img = 8'h5B;
            4'd3:    img = 8'h4F;
            4'd4:    img = 8'h66;
            4'd5:    img = 8'h6D;
            4'd6:    img = 8'h7D;
            4'd7:    img = 8'h07;
            4'd8:    img = 8'h7F;
            4'd9:    img = 8'h6F;
            default: img = 8'h00;
        endcase
        return img;
    endfunction

    // Clamp the digit count into 1..MAX_DIGITS
    function automatic logic [NUM_W-1:0] eff_digits(input logic [NUM_W-1:0] d);
        logic [NUM_W-1:0] n;
        if (d == '0)
            n = NUM_W'(1);
        else if (d > NUM_W'(MAX_DIGITS))
            n = NUM_W'(MAX_DIGITS);
        else
            n = d;
        return n;
    endfunction

endpackage

@@ src/seven_segment_scan_blink.sv @@
// Top level of the multiplexed seven-segment display controller.
`timescale 1ns / 1ps

// Multiplexed seven-segment controller with digit and dot blinking. Each
// input beat is a write (fill the segment memory from packed BCD), a dot
// toggle, or a refresh tick; only a refresh tick yields an output beat,
// carrying the segment image and index of the next scanned digit. Mode 3
// beats are dropped without effect. One beat is accepted every clock while
// in_stall is low: a beat lands in the input register, is applied against
// the scan state once go is high, and a refresh result is loaded into the
// output register at the end of that cycle. in_stall rises only when a
// refresh beat is waiting and the output register is full and stalled;
// writes and toggles pass through regardless. Reset sets the registers to
// eight digits with all blinking off and clears the segment memory at
// once, with no clearing pass. Program the registers only while no beat is
// in flight; the side effects of a register write (memory clear, counter
// clear) are registered alongside the new value and then applied to the
// scan state.
module seven_segment_scan_blink (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ssb_pkg::ADDR_W-1:0]   paddr,
    input  logic [ssb_pkg::DATA_W-1:0]   pwdata,
    output logic [ssb_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   mode,
    input  logic [ssb_pkg::VALUES_W-1:0] digit_values,
    input  logic [ssb_pkg::NUM_W-1:0]    value_count,
    input  logic [ssb_pkg::DIGIT_W-1:0]  position,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ssb_pkg::SEG_W-1:0]    segments,
    output logic [ssb_pkg::DIGIT_W-1:0]  digit_select
);

    ssb_pkg::cfg_t     cfg;
    ssb_pkg::cfg_evt_t cfg_evt;

    // Input register stage
    logic              s1_valid_reg, s1_valid_next;
    ssb_pkg::item_t    s1_item_reg;

    // Output register stage
    logic              out_valid_reg, out_valid_next;
    ssb_pkg::result_t  out_res_reg;

    ssb_pkg::result_t  res;
    logic              res_valid;
    logic              out_block;
    logic              go;
    logic              in_acc;

    ssb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .cfg_evt (cfg_evt)
    );

    ssb_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_evt   (cfg_evt),
        .go        (go),
        .item      (s1_item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Hold a refresh beat only while the output register cannot take it
    assign out_block = out_valid_reg & out_stall;
    assign go        = s1_valid_reg & ~(res_valid & out_block);
    assign in_stall  = s1_valid_reg & ~go;
    assign in_acc    = in_valid & ~in_stall;

    assign s1_valid_next  = in_stall ? 1'b1 : in_valid;
    assign out_valid_next = (go & res_valid) ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            s1_item_reg <= {mode, digit_values, value_count, position};
        if (go & res_valid)
            out_res_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign segments     = out_res_reg.segments;
    assign digit_select = out_res_reg.digit_select;

endmodule

@@ src/ssb_regs.sv @@
// Register file behind the APB-style configuration port.
`timescale 1ns / 1ps

module ssb_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ssb_pkg::ADDR_W-1:0] paddr,
    input  logic [ssb_pkg::DATA_W-1:0] pwdata,
    output logic [ssb_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output ssb_pkg::cfg_t              cfg,
    output ssb_pkg::cfg_evt_t          cfg_evt
);

    ssb_pkg::cfg_t     cfg_reg, cfg_next;
    ssb_pkg::cfg_evt_t evt_reg, evt_next;
    logic              wr_en;
    logic [2:0]        idx;

    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[ssb_pkg::ADDR_W-1:2];
    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        evt_next = '0;
        if (wr_en)
        begin
            unique case (idx)
                ssb_pkg::REG_DIGITS:
                begin
                    cfg_next.digits_in_use = pwdata[ssb_pkg::NUM_W-1:0];
                    evt_next.restart       = 1'b1;
                end
                ssb_pkg::REG_DIGIT_PERIOD:
                begin
                    cfg_next.digit_blink_period = pwdata[ssb_pkg::PERIOD_W-1:0];
                    evt_next.digit_cnt_clr      = 1'b1;
                end
                ssb_pkg::REG_DIGIT_MASK:
                    cfg_next.digit_blink_mask = pwdata[ssb_pkg::MASK_W-1:0];
                ssb_pkg::REG_DOT_PERIOD:
                begin
                    cfg_next.dot_blink_period = pwdata[ssb_pkg::PERIOD_W-1:0];
                    evt_next.dot_cnt_clr      = 1'b1;
                end
                ssb_pkg::REG_DOT_MASK:
                    cfg_next.dot_blink_mask = pwdata[ssb_pkg::MASK_W-1:0];
                ssb_pkg::REG_ALARM:
                    cfg_next.alarm_dot = pwdata[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            ssb_pkg::REG_DIGITS:
                prdata = ssb_pkg::DATA_W'(cfg_reg.digits_in_use);
            ssb_pkg::REG_DIGIT_PERIOD:
                prdata = ssb_pkg::DATA_W'(cfg_reg.digit_blink_period);
            ssb_pkg::REG_DIGIT_MASK:
                prdata = ssb_pkg::DATA_W'(cfg_reg.digit_blink_mask);
            ssb_pkg::REG_DOT_PERIOD:
                prdata = ssb_pkg::DATA_W'(cfg_reg.dot_blink_period);
            ssb_pkg::REG_DOT_MASK:
                prdata = ssb_pkg::DATA_W'(cfg_reg.dot_blink_mask);
            ssb_pkg::REG_ALARM:
                prdata = ssb_pkg::DATA_W'(cfg_reg.alarm_dot);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{digits_in_use: ssb_pkg::NUM_W'(ssb_pkg::MAX_DIGITS), default: '0};
            evt_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            evt_reg <= evt_next;
        end
    end

    assign cfg     = cfg_reg;
    assign cfg_evt = evt_reg;

endmodule

@@ src/ssb_scan.sv @@
// Segment memory, scan position, blink counters and result formation.
`timescale 1ns / 1ps

module ssb_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  ssb_pkg::cfg_t     cfg,
    input  ssb_pkg::cfg_evt_t cfg_evt,
    input  logic              go,
    input  ssb_pkg::item_t    item,
    output logic              res_valid,
    output ssb_pkg::result_t  res
);

    logic [ssb_pkg::SEG_W-1:0]    mem_reg  [ssb_pkg::MAX_DIGITS];
    logic [ssb_pkg::SEG_W-1:0]    mem_next [ssb_pkg::MAX_DIGITS];
    logic [ssb_pkg::DIGIT_W-1:0]  active_reg, active_next;
    logic [ssb_pkg::PERIOD_W-1:0] digit_cnt_reg, digit_cnt_next;
    logic [ssb_pkg::PERIOD_W-1:0] dot_cnt_reg, dot_cnt_next;

    logic [ssb_pkg::NUM_W-1:0]    n_digits;
    logic [ssb_pkg::NUM_W-1:0]    active_inc;
    logic [ssb_pkg::DIGIT_W-1:0]  active_adv;
    logic [ssb_pkg::NUM_W-1:0]    vc_clamp;
    logic [ssb_pkg::NUM_W-1:0]    wr_limit;
    logic [ssb_pkg::PERIOD_W-1:0] digit_cnt_inc, digit_cnt_adv;
    logic [ssb_pkg::PERIOD_W-1:0] dot_cnt_inc, dot_cnt_adv;
    logic                         digit_on, dot_on, at_first;
    logic                         digit_blank, dot_hit, dot_late, alarm_flip;
    logic [ssb_pkg::SEG_W-1:0]    seg_raw, seg_a;
    logic                         dot_val;

    assign n_digits   = ssb_pkg::eff_digits(cfg.digits_in_use);
    assign active_inc = {1'b0, active_reg} + ssb_pkg::NUM_W'(1);
    assign active_adv = (active_inc == n_digits) ? '0 : active_inc[ssb_pkg::DIGIT_W-1:0];
    assign at_first   = (active_adv == '0);

    // Counters stay below their period, so wrap is a compare against period
    assign digit_on      = (cfg.digit_blink_period != '0);
    assign digit_cnt_inc = (digit_cnt_reg + 16'd1 == cfg.digit_blink_period) ? '0
                                                                           : digit_cnt_reg + 16'd1;
    assign digit_cnt_adv = (digit_on && at_first) ? digit_cnt_inc : digit_cnt_reg;

    assign dot_on      = (cfg.dot_blink_period != '0);
    assign dot_cnt_inc = (dot_cnt_reg + 16'd1 == cfg.dot_blink_period) ? '0
                                                                     : dot_cnt_reg + 16'd1;
    assign dot_cnt_adv = (dot_on && at_first) ? dot_cnt_inc : dot_cnt_reg;

    assign digit_blank = digit_on && cfg.digit_blink_mask[active_adv] &&
                         (digit_cnt_adv > (cfg.digit_blink_period >> 1));
    assign dot_hit     = dot_on && cfg.dot_blink_mask[active_adv];
    assign dot_late    = dot_cnt_adv > (cfg.dot_blink_period >> 1);
    assign alarm_flip  = dot_on && cfg.alarm_dot && (active_adv == ssb_pkg::ALARM_DIGIT);

    assign seg_raw = mem_reg[active_adv];
    assign seg_a   = digit_blank ? '0 : seg_raw;

    always_comb
    begin
        if (dot_hit)
            dot_val = dot_late ? 1'b0 : ~seg_a[ssb_pkg::DOT_BIT];
        else
            dot_val = seg_a[ssb_pkg::DOT_BIT];
    end

    assign res.segments     = {dot_val ^ alarm_flip, seg_a[ssb_pkg::DOT_BIT-1:0]};
    assign res.digit_select = active_adv;
    assign res_valid        = (item.mode == ssb_pkg::MODE_REFRESH);

    // Nibbles written: min(value_count, nibble count, digits in use)
    assign vc_clamp = (item.value_count > ssb_pkg::NUM_W'(ssb_pkg::MAX_DIGITS))
                      ? ssb_pkg::NUM_W'(ssb_pkg::MAX_DIGITS) : item.value_count;
    assign wr_limit = (vc_clamp < n_digits) ? vc_clamp : n_digits;

    always_comb
    begin
        mem_next       = mem_reg;
        active_next    = active_reg;
        digit_cnt_next = digit_cnt_reg;
        dot_cnt_next   = dot_cnt_reg;
        if (cfg_evt.restart || cfg_evt.digit_cnt_clr || cfg_evt.dot_cnt_clr)
        begin
            if (cfg_evt.restart)
            begin
                for (int i = 0; i < ssb_pkg::MAX_DIGITS; i++)
                    mem_next[i] = '0;
                active_next = ssb_pkg::DIGIT_W'(n_digits - ssb_pkg::NUM_W'(1));
            end
            if (cfg_evt.digit_cnt_clr)
                digit_cnt_next = '0;
            if (cfg_evt.dot_cnt_clr)
                dot_cnt_next = '0;
        end
        else if (go)
        begin
            unique case (item.mode)
                ssb_pkg::MODE_WRITE:
                begin
                    for (int i = 0; i < ssb_pkg::MAX_DIGITS; i++)
                        mem_next[i] = (ssb_pkg::NUM_W'(i) < wr_limit)
                                      ? ssb_pkg::seg_image(item.digit_values[4*i +: 4]) : '0;
                end
                ssb_pkg::MODE_TOGGLE:
                    mem_next[item.position][ssb_pkg::DOT_BIT] =
                        ~mem_reg[item.position][ssb_pkg::DOT_BIT];
                ssb_pkg::MODE_REFRESH:
                begin
                    active_next    = active_adv;
                    digit_cnt_next = digit_cnt_adv;
                    dot_cnt_next   = dot_cnt_adv;
                end
                default:
                    active_next = active_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ssb_pkg::MAX_DIGITS; i++)
                mem_reg[i] <= '0;
            active_reg    <= ssb_pkg::DIGIT_W'(ssb_pkg::MAX_DIGITS - 1);
            digit_cnt_reg <= '0;
            dot_cnt_reg   <= '0;
        end
        else
        begin
            mem_reg       <= mem_next;
            active_reg    <= active_next;
            digit_cnt_reg <= digit_cnt_next;
            dot_cnt_reg   <= dot_cnt_next;
        end
    end

endmodule

@@ src/ssb_checker.sv @@
// Port-level checker for the display controller, bound to the top level.
`timescale 1ns / 1ps
`include "seven_segment_scan_blink_macros.svh"

module ssb_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [1:0]                   mode,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [ssb_pkg::SEG_W-1:0]    segments,
    input  logic [ssb_pkg::DIGIT_W-1:0]  digit_select
);

    // Hold a stalled output beat
    `SSB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(segments) && $stable(digit_select), "stalled output beat changed")

    // Input backpressure only comes from a blocked output
    `SSB_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output backpressure")

    // A fresh output beat follows an accepted refresh beat, through the input register
    `SSB_ASSERT_NOW(a_out_origin, $rose(out_valid), $past(in_valid && !in_stall && (mode == ssb_pkg::MODE_REFRESH), 2), "output beat without a refresh beat")

endmodule

bind seven_segment_scan_blink ssb_checker u_ssb_checker (.*);
